[sv/bgd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bgd_pkg;

    localparam int AMOUNT_W   = 20;
    localparam int DENOM_W    = 16;
    localparam int COUNT_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int MAX_DENOM  = 5;
    localparam int DIV_CNT_W  = $clog2(AMOUNT_W);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DENOM_0       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEPOSIT_LIMIT = 3'd5;

    // command codes
    localparam logic [1:0] CMD_CHECK    = 2'd0;
    localparam logic [1:0] CMD_WITHDRAW = 2'd1;
    localparam logic [1:0] CMD_DEPOSIT  = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_SHORT   = 2'd2;

    localparam logic [COUNT_W-1:0]  COUNT_MAX           = '1;
    localparam logic [AMOUNT_W-1:0] DEPOSIT_LIMIT_RESET = 20'd2000;

    localparam logic [DENOM_W-1:0] DENOM_RESET [MAX_DENOM] =
        '{16'd10, 16'd20, 16'd50, 16'd100, 16'd200};

    typedef struct packed {
        logic [1:0]          cmd;
        logic [AMOUNT_W-1:0] amount;
    } in_item_t;

    typedef struct packed {
        logic [1:0]          status;
        logic [AMOUNT_W-1:0] remainder;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic load_item;
        logic skip;
        logic div_start;
        logic div_step;
        logic take;
        logic mul;
        logic sub;
        logic commit;
    } bgd_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic invalid;
        logic skip;
        logic div_last;
        logic idx_zero;
        logic out_free;
    } bgd_stat_t;

    // multiple of ten: even and nibble sum (16 = 1 mod 5) divisible by five
    function automatic logic is_mult10(input logic [AMOUNT_W-1:0] a);
        logic [6:0] s;
        logic [4:0] t;
        s = 7'(a[3:0]) + 7'(a[7:4]) + 7'(a[11:8]) + 7'(a[15:12]) + 7'(a[19:16]);
        t = 5'(s[6:4]) + 5'(s[3:0]);
        if (t >= 5'd5) t = t - 5'd5;
        if (t >= 5'd5) t = t - 5'd5;
        if (t >= 5'd5) t = t - 5'd5;
        return (a[0] == 1'b0) && (t == 5'd0);
    endfunction

endpackage

`default_nettype wire

[sv/banknote_greedy_dispenser.sv]
// Sequence: an invalid request goes from validation straight to the commit;
// otherwise each denomination is divided (select, bit-serial divider, take,
// multiply, subtract) or, where it cannot be used, skipped at the select step.
// Throughput: one request at a time; a held result delays the commit of the
// next one.
// Reset (rst_n, async, active low): counts cleared, note values 10/20/50/100/200.
`timescale 1ns / 1ps
`default_nettype none

module banknote_greedy_dispenser
    import bgd_pkg::*;
#(
    parameter int NUM_DENOM = 5
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    // configuration writes
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [AMOUNT_W-1:0]  cfg_data,

    // request channel
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire in_item_t             in_data,

    // result channel
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output out_item_t                 out_data
);

    // The controller sequences each request through validation and a walk
    // of the denominations from the largest down. For each one the datapath
    // divides the remaining amount by the note value, clamps the quotient to
    // the notes on hand (not for deposits), multiplies back and subtracts.
    // A commit step then applies the counts (withdraw only when nothing is
    // left over; deposit with saturation) and fills the output register.
    // A new request is taken while the previous result still waits there.

    bgd_cmd_t  cmd;
    bgd_stat_t stat;

    bgd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bgd_dp #(
        .NUM_DENOM (NUM_DENOM)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

`default_nettype wire

[sv/bgd_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module bgd_ctrl
    import bgd_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire bgd_stat_t stat,
    output bgd_cmd_t       cmd
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b00000001,
        S_VALID  = 8'b00000010,
        S_SELECT = 8'b00000100,
        S_DIV    = 8'b00001000,
        S_TAKE   = 8'b00010000,
        S_MUL    = 8'b00100000,
        S_SUB    = 8'b01000000,
        S_COMMIT = 8'b10000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_VALID;
                end
            end
            S_VALID:
            begin
                state_next = stat.invalid ? S_COMMIT : S_SELECT;
            end
            S_SELECT:
            begin
                if (stat.skip)
                begin
                    cmd.skip   = 1'b1;
                    state_next = stat.idx_zero ? S_COMMIT : S_SELECT;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = S_TAKE;
                end
            end
            S_TAKE:
            begin
                cmd.take   = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_SUB;
            end
            S_SUB:
            begin
                cmd.sub    = 1'b1;
                state_next = stat.idx_zero ? S_COMMIT : S_SELECT;
            end
            S_COMMIT:
            begin
                // hold until the output register can take the result
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[sv/bgd_dp.sv]
`timescale 1ns / 1ps
`default_nettype none

module bgd_dp
    import bgd_pkg::*;
#(
    parameter int NUM_DENOM = 5
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [AMOUNT_W-1:0]  cfg_data,
    input  wire in_item_t             in_data,
    input  wire logic                 out_ready,
    output logic                      out_valid,
    output out_item_t                 out_data,
    input  wire bgd_cmd_t             cmd,
    output bgd_stat_t                 stat
);

    localparam int IDX_W = (NUM_DENOM > 1) ? $clog2(NUM_DENOM) : 1;

    logic [DENOM_W-1:0]   denom_reg [NUM_DENOM];
    logic [AMOUNT_W-1:0]  limit_reg;
    logic [COUNT_W-1:0]   count_reg [NUM_DENOM];
    logic [AMOUNT_W-1:0]  take_reg  [NUM_DENOM];

    logic [1:0]           cmd_reg;
    logic [AMOUNT_W-1:0]  amount_reg;
    logic [AMOUNT_W-1:0]  rest_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic                 inval_reg;

    logic [DENOM_W-1:0]   rem_reg;
    logic [AMOUNT_W-1:0]  quo_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [AMOUNT_W-1:0]  take_cur_reg;
    logic [AMOUNT_W-1:0]  prod_reg;

    logic                 out_valid_reg;
    out_item_t            out_data_reg;

    logic [DENOM_W-1:0]   d_cur;
    logic [COUNT_W-1:0]   c_cur;
    logic                 invalid;
    logic                 full;
    logic                 rest_zero;
    logic [DENOM_W:0]     r_sh;
    logic                 ge;
    logic [DENOM_W:0]     diff;
    logic [AMOUNT_W-1:0]  c_ext;
    logic [AMOUNT_W-1:0]  take_val;
    logic [35:0]          prod_full;
    out_item_t            result;

    assign d_cur     = denom_reg[idx_reg];
    assign c_cur     = count_reg[idx_reg];
    assign full      = (cmd_reg == CMD_DEPOSIT);
    assign rest_zero = (rest_reg == '0);

    always_comb
    begin
        case (cmd_reg)
            CMD_CHECK:    invalid = 1'b0;
            CMD_WITHDRAW: invalid = (amount_reg == '0) || !is_mult10(amount_reg);
            CMD_DEPOSIT:  invalid = (amount_reg == '0) || (amount_reg > limit_reg)
                                    || !is_mult10(amount_reg);
            default:      invalid = 1'b1;
        endcase
    end

    // restoring divider, one quotient bit a cycle
    assign r_sh = {rem_reg, quo_reg[AMOUNT_W-1]};
    assign ge   = (r_sh >= {1'b0, d_cur});
    assign diff = r_sh - {1'b0, d_cur};

    assign c_ext    = AMOUNT_W'(c_cur);
    assign take_val = (full || (quo_reg <= c_ext)) ? quo_reg : c_ext;

    // take never exceeds rest/d, so the product fits the amount width
    assign prod_full = 36'(take_cur_reg) * 36'(d_cur);

    always_comb
    begin
        if (inval_reg)
        begin
            result.status    = ST_INVALID;
            result.remainder = '0;
        end
        else if (cmd_reg == CMD_DEPOSIT)
        begin
            result.status    = ST_OK;
            result.remainder = rest_reg;
        end
        else
        begin
            result.status    = rest_zero ? ST_OK : ST_SHORT;
            result.remainder = rest_reg;
        end
    end

    assign stat.invalid  = invalid;
    assign stat.skip     = (d_cur == '0) || (rest_reg < AMOUNT_W'(d_cur));
    assign stat.div_last = (cnt_reg == '0);
    assign stat.idx_zero = (idx_reg == '0);
    assign stat.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // configuration, note counts, output flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_DENOM; i++)
            begin
                denom_reg[i] <= DENOM_RESET[i];
                count_reg[i] <= '0;
            end
            limit_reg     <= DEPOSIT_LIMIT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < NUM_DENOM; i++)
            begin
                if (cfg_wr_en && (cfg_index == REG_DENOM_0 + CFG_IDX_W'(i)))
                begin
                    denom_reg[i] <= cfg_data[DENOM_W-1:0];
                end
            end
            if (cfg_wr_en && (cfg_index == REG_DEPOSIT_LIMIT))
            begin
                limit_reg <= cfg_data;
            end

            if (cmd.commit && !inval_reg)
            begin
                for (int i = 0; i < NUM_DENOM; i++)
                begin
                    if (cmd_reg == CMD_DEPOSIT)
                    begin
                        if ((AMOUNT_W+1)'(count_reg[i]) + (AMOUNT_W+1)'(take_reg[i])
                            > (AMOUNT_W+1)'(COUNT_MAX))
                        begin
                            count_reg[i] <= COUNT_MAX;
                        end
                        else
                        begin
                            count_reg[i] <= count_reg[i] + take_reg[i][COUNT_W-1:0];
                        end
                    end
                    else if ((cmd_reg == CMD_WITHDRAW) && rest_zero)
                    begin
                        count_reg[i] <= count_reg[i] - take_reg[i][COUNT_W-1:0];
                    end
                end
            end

            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            cmd_reg    <= in_data.cmd;
            amount_reg <= in_data.amount;
            rest_reg   <= in_data.amount;
            idx_reg    <= IDX_W'(NUM_DENOM - 1);
        end
        inval_reg <= invalid;

        if (cmd.skip)
        begin
            take_reg[idx_reg] <= '0;
        end
        if (cmd.skip || cmd.sub)
        begin
            if (idx_reg != '0)
            begin
                idx_reg <= idx_reg - 1'b1;
            end
        end

        if (cmd.div_start)
        begin
            rem_reg <= '0;
            quo_reg <= rest_reg;
            cnt_reg <= DIV_CNT_W'(AMOUNT_W - 1);
        end
        else if (cmd.div_step)
        begin
            rem_reg <= ge ? diff[DENOM_W-1:0] : r_sh[DENOM_W-1:0];
            quo_reg <= {quo_reg[AMOUNT_W-2:0], ge};
            cnt_reg <= cnt_reg - 1'b1;
        end

        if (cmd.take)
        begin
            take_cur_reg      <= take_val;
            take_reg[idx_reg] <= take_val;
        end
        if (cmd.mul)
        begin
            prod_reg <= prod_full[AMOUNT_W-1:0];
        end
        if (cmd.sub)
        begin
            rest_reg <= rest_reg - prod_reg;
        end

        if (cmd.commit)
        begin
            out_data_reg <= result;
        end
    end

endmodule

`default_nettype wire

[bench/tb_banknote_greedy_dispenser.sv]
`timescale 1ns / 1ps

// Cash box dispenser bench.
// A predictor inside the bench holds its own copy of the note counts, the note values and
// the deposit limit. Every request that the DUT accepts is run through the predictor, and
// the result it gives is queued. A monitor takes each result that the DUT hands over and
// compares it, field by field, with the oldest queued one. The tests run in turn: the
// reset box, extreme note settings, a long result hold-off, then random traffic across
// a range of settings.
module tb_banknote_greedy_dispenser;
    import bgd_pkg::*;

    // cmd value that the block does not use
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    // deposits and withdrawals go in whole tens
    localparam int NOTE_STEP = 10;

    localparam int HOLD_CYCLES     = 400;   // long result hold-off
    localparam int SETTLE_CYCLES   = 150;   // time left for any stray result to show up
    localparam int WATCHDOG_LIMIT  = 5000;  // cycles with no handshake at all
    localparam int RANDOM_PHASES   = 10;
    localparam int ITEMS_PER_PHASE = 112;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [AMOUNT_W-1:0]  cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    in_item_t             in_data;
    logic                 out_valid;
    logic                 out_ready;
    out_item_t            out_data;

    // predictor state: note values, deposit limit, notes in the box
    logic [DENOM_W-1:0]  box_denom [MAX_DENOM];
    logic [AMOUNT_W-1:0] box_dep_limit;
    logic [COUNT_W-1:0]  box_notes [MAX_DENOM];
    // notes taken from each denomination by the last split
    logic [AMOUNT_W-1:0] split_take [MAX_DENOM];

    out_item_t pending_results [$];

    int fail_count;
    bit gaps_on;       // random idling on both sides
    bit hold_results;  // asks the result sink for one long hold-off

    banknote_greedy_dispenser u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Greedy split from the largest note down. Without full_take each
    // denomination gives at most the notes on hand; a deposit takes the
    // whole quotient. Zero note values are passed over.
    function automatic logic [AMOUNT_W-1:0] greedy_split(input logic [AMOUNT_W-1:0] amt,
                                                          input bit full_take);
        logic [AMOUNT_W-1:0] rest;
        logic [AMOUNT_W-1:0] need;
        rest = amt;
        for (int i = MAX_DENOM - 1; i >= 0; i--)
        begin
            split_take[i] = '0;
            if (box_denom[i] != '0 && rest >= box_denom[i])
            begin
                need = rest / box_denom[i];
                if (full_take || need <= box_notes[i])
                    split_take[i] = need;
                else
                    split_take[i] = box_notes[i];
                rest = rest - split_take[i] * box_denom[i];
            end
        end
        return rest;
    endfunction

    // Result of one request; updates the note counts as the block would.
    function automatic out_item_t dispense_outcome(input in_item_t req);
        out_item_t           res;
        logic [AMOUNT_W:0]   sum;
        res.status    = ST_OK;
        res.remainder = '0;
        case (req.cmd)
            CMD_CHECK:
            begin
                // no validation, nothing changes
                res.remainder = greedy_split(req.amount, 1'b0);
                if (res.remainder != '0)
                    res.status = ST_SHORT;
            end
            CMD_WITHDRAW:
            begin
                if (req.amount == '0 || req.amount % NOTE_STEP != 0)
                    res.status = ST_INVALID;
                else
                begin
                    res.remainder = greedy_split(req.amount, 1'b0);
                    if (res.remainder != '0)
                        res.status = ST_SHORT;
                    else
                        for (int i = 0; i < MAX_DENOM; i++)
                            box_notes[i] = box_notes[i] - COUNT_W'(split_take[i]);
                end
            end
            CMD_DEPOSIT:
            begin
                if (req.amount == '0 || req.amount > box_dep_limit ||
                    req.amount % NOTE_STEP != 0)
                    res.status = ST_INVALID;
                else
                begin
                    // leftover is reported but not stored; counts saturate
                    res.remainder = greedy_split(req.amount, 1'b1);
                    for (int i = 0; i < MAX_DENOM; i++)
                    begin
                        sum = {{(AMOUNT_W + 1 - COUNT_W){1'b0}}, box_notes[i]} + split_take[i];
                        box_notes[i] = (sum > COUNT_MAX) ? COUNT_MAX : COUNT_W'(sum);
                    end
                end
            end
            default:
                res.status = ST_INVALID;
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Result monitor and watchdog
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("MISMATCH at %0t: %s: got %0d, expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    // Handshakes are sampled at the rising edge, before the NBA updates
    // of that edge, so both channels see settled values.
    always @(posedge clk)
    begin : result_monitor
        out_item_t want;
        int        quiet_cycles;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                    report_mismatch("result with no request outstanding",
                                    out_data.remainder, 0);
                else
                begin
                    want = pending_results.pop_front();
                    if (out_data.status !== want.status)
                        report_mismatch("status", out_data.status, want.status);
                    if (out_data.remainder !== want.remainder)
                        report_mismatch("remainder", out_data.remainder, want.remainder);
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
        else
            quiet_cycles = 0;
    end

    // ------------------------------------------------------------------
    // Result sink: with gaps on, random stalls, mostly short, some long; one long
    // hold-off on request from the tests.
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int stall_left;
        int roll;
        stall_left = 0;
        out_ready  = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_results)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_results = 1'b0;
            end
            else if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else if (!gaps_on)
                out_ready <= 1'b1;
            else
            begin
                roll = $urandom_range(0, 99);
                if (roll < 75)
                    out_ready <= 1'b1;
                else
                begin
                    out_ready <= 1'b0;
                    stall_left = (roll < 97) ? $urandom_range(0, 2) : $urandom_range(10, 60);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Offers one request and returns at the edge it is taken. Valid is
    // left high so a back-to-back request only changes the payload.
    task automatic send_request(input logic [1:0] cmd, input logic [AMOUNT_W-1:0] amount);
        in_item_t req;
        int       gap;
        int       roll;
        req.cmd    = cmd;
        req.amount = amount;
        gap = 0;
        if (gaps_on)
        begin
            roll = $urandom_range(0, 99);
            if (roll >= 93)
                gap = $urandom_range(8, 60);
            else if (roll >= 55)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do
            @(posedge clk);
        while (!in_ready);
        pending_results.push_back(dispense_outcome(req));
    endtask

    // Sender pause: drop valid and wait for every outstanding result.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [AMOUNT_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        if (idx == REG_DEPOSIT_LIMIT)
            box_dep_limit = value;
        else
            box_denom[idx - REG_DENOM_0] = value[DENOM_W-1:0];
    endtask

    // Writes all six registers; only called with the block idle.
    task automatic apply_setting(input logic [DENOM_W-1:0] d0, input logic [DENOM_W-1:0] d1,
                                 input logic [DENOM_W-1:0] d2, input logic [DENOM_W-1:0] d3,
                                 input logic [DENOM_W-1:0] d4, input logic [AMOUNT_W-1:0] lim);
        write_reg(REG_DENOM_0 + 3'd0, AMOUNT_W'(d0));
        write_reg(REG_DENOM_0 + 3'd1, AMOUNT_W'(d1));
        write_reg(REG_DENOM_0 + 3'd2, AMOUNT_W'(d2));
        write_reg(REG_DENOM_0 + 3'd3, AMOUNT_W'(d3));
        write_reg(REG_DENOM_0 + 3'd4, AMOUNT_W'(d4));
        write_reg(REG_DEPOSIT_LIMIT, lim);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset note values, empty box: invalid amounts, short box, exact
    // withdrawals and the field extremes.
    task automatic test_empty_box();
        send_request(CMD_CHECK, 20'd0);
        send_request(CMD_CHECK, 20'd10);
        send_request(CMD_WITHDRAW, 20'd0);
        send_request(CMD_WITHDRAW, 20'd25);
        send_request(CMD_DEPOSIT, 20'd2010);       // just over the limit
        send_request(CMD_DEPOSIT, 20'd0);
        send_request(CMD_UNUSED, 20'd500);
        send_request(CMD_DEPOSIT, 20'd2000);       // exactly the limit
        send_request(CMD_DEPOSIT, 20'd380);        // one of each note
        send_request(CMD_WITHDRAW, 20'd50);
        send_request(CMD_WITHDRAW, 20'd60);        // split runs out of small notes
        send_request(CMD_CHECK, '1);
        send_request(CMD_WITHDRAW, 20'd1048570);
        send_request(CMD_DEPOSIT, 20'd1048570);
        send_request(CMD_WITHDRAW, 20'd2200);      // empties the 200s
        wait_idle();
    endtask

    // Zero note values, all-max note values, zero limit, unit notes that
    // drive the counts into saturation, and deposits that leave change.
    task automatic test_denomination_extremes();
        apply_setting(16'd0, 16'd30, 16'd70, 16'd0, 16'd500, '1);
        send_request(CMD_DEPOSIT, 20'd1048570);
        send_request(CMD_DEPOSIT, 20'd40);         // 10 left over, not stored
        send_request(CMD_CHECK, 20'd130);
        wait_idle();

        apply_setting('1, '1, '1, '1, '1, '0);
        send_request(CMD_DEPOSIT, 20'd10);         // limit of zero refuses all
        send_request(CMD_CHECK, '1);
        send_request(CMD_WITHDRAW, 20'd131070);
        wait_idle();

        apply_setting(16'd1, 16'd1, 16'd1, 16'd1, 16'd1, '1);
        send_request(CMD_DEPOSIT, 20'd1048570);    // largest count saturates
        send_request(CMD_DEPOSIT, 20'd70000);
        send_request(CMD_WITHDRAW, 20'd65530);
        send_request(CMD_CHECK, 20'd65535);
        wait_idle();
    endtask

    // Results held off for a long stretch while requests keep coming, so
    // the block fills and stalls its input; then the sender waits for all.
    task automatic test_backpressure();
        apply_setting(16'd10, 16'd20, 16'd50, 16'd100, 16'd200, 20'd2000);
        gaps_on      = 1'b0;
        hold_results = 1'b1;
        for (int i = 0; i < 10; i++)
            send_request(CMD_DEPOSIT, 20'(NOTE_STEP * $urandom_range(1, 200)));
        wait_idle();
        gaps_on = 1'b1;
    endtask

    // Reset or random note settings per phase; mostly well-formed amounts, the rest
    // arbitrary bits and corner values. Every third phase runs without gaps.
    task automatic test_random_traffic();
        logic [DENOM_W-1:0]  d [MAX_DENOM];
        logic [AMOUNT_W-1:0] lim;
        logic [AMOUNT_W-1:0] amount;
        logic [1:0]          cmd;
        int                  roll;
        int unsigned         step;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p % 4)
                0:
                begin
                    d[0] = 16'd10; d[1] = 16'd20; d[2] = 16'd50;
                    d[3] = 16'd100; d[4] = 16'd200;
                    lim = 20'd2000;
                end
                1:
                begin
                    // ascending tens, loosely like real currencies
                    step = NOTE_STEP * $urandom_range(1, 3);
                    for (int i = 0; i < MAX_DENOM; i++)
                    begin
                        d[i] = DENOM_W'(step);
                        step = step * $urandom_range(2, 5);
                    end
                    lim = 20'($urandom_range(100, 200000));
                end
                2:
                begin
                    for (int i = 0; i < MAX_DENOM; i++)
                        d[i] = DENOM_W'($urandom_range(1, 65535));
                    lim = 20'($urandom_range(0, 1048575));
                end
                default:
                begin
                    for (int i = 0; i < MAX_DENOM; i++)
                        d[i] = DENOM_W'($urandom_range(1, 60));
                    lim = 20'($urandom_range(10, 5000));
                end
            endcase
            apply_setting(d[0], d[1], d[2], d[3], d[4], lim);
            gaps_on = (p % 3 != 2);

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 45)
                    amount = 20'(NOTE_STEP * $urandom_range(1, 200));
                else if (roll < 65)
                    amount = (box_dep_limit >= NOTE_STEP) ?
                             20'(NOTE_STEP * $urandom_range(1, box_dep_limit / NOTE_STEP)) :
                             20'(NOTE_STEP);
                else if (roll < 80)
                    amount = 20'($urandom_range(0, 1048575));
                else if (roll < 90)
                    amount = 20'(box_denom[$urandom_range(0, MAX_DENOM - 1)] *
                                 $urandom_range(1, 3));
                else
                    case ($urandom_range(0, 5))
                        0: amount = '0;
                        1: amount = '1;
                        2: amount = 20'd1 << $urandom_range(0, AMOUNT_W - 1);
                        3: amount = 20'd1048570;
                        4: amount = box_dep_limit;
                        default: amount = box_dep_limit + 20'(NOTE_STEP);
                    endcase

                roll = $urandom_range(0, 99);
                if (roll < 40)
                    cmd = CMD_DEPOSIT;
                else if (roll < 75)
                    cmd = CMD_WITHDRAW;
                else if (roll < 95)
                    cmd = CMD_CHECK;
                else
                    cmd = CMD_UNUSED;
                send_request(cmd, amount);
            end
            wait_idle();
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        in_data      = '0;
        gaps_on      = 1'b1;
        hold_results = 1'b0;
        fail_count   = 0;

        box_denom     = DENOM_RESET;
        box_dep_limit = DEPOSIT_LIMIT_RESET;
        for (int i = 0; i < MAX_DENOM; i++)
            box_notes[i] = '0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_box();
        test_denomination_extremes();
        test_backpressure();
        test_random_traffic();

        // anything still in flight would show up as an extra result
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
